@@ rtl/core/sbr_pkg.sv @@
package sbr_pkg;

    localparam int IDX_W     = 64;
    localparam int BYTE_W    = 8;
    localparam int WCAP_W    = 7;
    localparam int PEND_W    = 7;
    localparam int DRAIN_MAX = 64;
    localparam int DRAIN_W   = 7;

    localparam logic [WCAP_W-1:0] WCAP_RESET = 7'd64;

    typedef struct packed {
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] in_byte;
        logic              segment_empty;
        logic              segment_first;
        logic              segment_last;
        logic              stream_end;
        logic [IDX_W-1:0]  window_end;
    } sbr_item_t;

    typedef struct packed {
        logic closed;
        logic store_empty;
        logic pending_ok;
    } sbr_status_t;

endpackage

@@ rtl/core/sbr_ram.sv @@
module sbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/sbr_front.sv @@
module sbr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [6:0]        cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [135:0]      s_axis_tdata,
    input  logic [2:0]        s_axis_tuser,
    input  logic              s_axis_tlast,
    output logic              pop_valid,
    input  logic              pop_ready,
    output sbr_pkg::sbr_item_t pop_item
);
    import sbr_pkg::*;

    logic [WCAP_W-1:0] wcap_reg;
    sbr_item_t         q_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [IDX_W:0]    we_sum;
    sbr_item_t         new_item;
    logic              push, pop;

    assign cfg_ready = 1'b1;

    // saturated window end
    assign we_sum = {1'b0, s_axis_tdata[135:72]} + (IDX_W+1)'(wcap_reg);

    always_comb
    begin
        new_item.byte_index    = s_axis_tdata[63:0];
        new_item.in_byte       = s_axis_tdata[71:64];
        new_item.segment_empty = s_axis_tuser[0];
        new_item.segment_first = s_axis_tuser[1];
        new_item.stream_end    = s_axis_tuser[2];
        new_item.segment_last  = s_axis_tlast;
        new_item.window_end    = we_sum[IDX_W] ? '1 : we_sum[IDX_W-1:0];
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop_valid     = (count_reg != 2'd0);
    assign pop           = pop_valid && pop_ready;
    assign pop_item      = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcap_reg   <= WCAP_RESET;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                wcap_reg <= cfg_data;
            end
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ rtl/core/sbr_back.sv @@
module sbr_back #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  sbr_pkg::sbr_item_t pop_item,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,
    output logic               m_axis_tuser,
    output logic               m_axis_tlast,
    output sbr_pkg::sbr_status_t status
);
    import sbr_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } back_state_t;

    back_state_t        state_reg;
    sbr_item_t          item_reg;
    logic [IDX_W-1:0]   ne_reg, fi_reg, we_reg;
    logic [AW-1:0]      ne_slot_reg;
    logic [PW-1:0]      pending_reg;
    logic [CAPACITY-1:0] present_reg;
    logic               ign_reg, fk_reg, closed_reg;
    logic [DRAIN_W-1:0] n_reg;

    logic               out_valid_reg, out_flag_reg, out_last_reg, out_closed_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [PEND_W-1:0]  out_pend_reg;
    logic               out_free, out_load;

    logic [IDX_W-1:0]   we_cur, diff, fi_n, ne_inc;
    logic               ign_cur, live, acc, fk_n, close_now, close_after, last_n;
    logic [AW:0]        slot_sum;
    logic [AW-1:0]      wslot, slot_inc;
    logic               ram_we, ram_re;
    logic [BYTE_W-1:0]  ram_rdata;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pop_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        we_cur  = item_reg.segment_first ? item_reg.window_end : we_reg;
        ign_cur = item_reg.segment_first
                ? (closed_reg || (item_reg.window_end <= ne_reg)
                   || (item_reg.byte_index >= item_reg.window_end))
                : ign_reg;
        live    = !ign_cur && !closed_reg;
        diff    = item_reg.byte_index - ne_reg;
        acc     = live && !item_reg.segment_empty && (item_reg.byte_index >= ne_reg)
                  && (item_reg.byte_index < we_cur) && (diff < IDX_W'(CAPACITY));
        slot_sum = {1'b0, ne_slot_reg} + {1'b0, diff[AW-1:0]};
        wslot    = (slot_sum >= (AW+1)'(CAPACITY)) ? AW'(slot_sum - (AW+1)'(CAPACITY))
                                                  : slot_sum[AW-1:0];
        fk_n = fk_reg;
        fi_n = fi_reg;
        if (live && item_reg.segment_last && item_reg.stream_end)
        begin
            if (item_reg.segment_empty)
            begin
                if (item_reg.byte_index < we_cur)
                begin
                    fk_n = 1'b1;
                    fi_n = item_reg.byte_index;
                end
            end
            else if ((item_reg.byte_index < we_cur) && (item_reg.byte_index + 64'd1 < we_cur))
            begin
                fk_n = 1'b1;
                fi_n = item_reg.byte_index + 64'd1;
            end
        end
        close_now   = !closed_reg && fk_n && (ne_reg >= fi_n);
        ne_inc      = ne_reg + 64'd1;
        slot_inc    = (ne_slot_reg == AW'(CAPACITY - 1)) ? '0 : ne_slot_reg + AW'(1);
        close_after = fk_reg && (ne_inc >= fi_reg);
        last_n      = close_after || (n_reg == DRAIN_W'(DRAIN_MAX - 1))
                      || !present_reg[slot_inc];
    end

    assign ram_we = (state_reg == ST_EXEC) && acc;
    assign ram_re = (state_reg == ST_DRAIN) && !closed_reg && present_reg[ne_slot_reg];

    assign out_load = out_free
                      && (((state_reg == ST_DRAIN) && !ram_re) || (state_reg == ST_EMIT));

    sbr_ram #(.WIDTH(BYTE_W), .DEPTH(CAPACITY)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wslot),
        .wdata (item_reg.in_byte),
        .re    (ram_re),
        .raddr (ne_slot_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            item_reg <= pop_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ne_reg         <= '0;
            ne_slot_reg    <= '0;
            fi_reg         <= '0;
            we_reg         <= '0;
            fk_reg         <= 1'b0;
            ign_reg        <= 1'b0;
            closed_reg     <= 1'b0;
            pending_reg    <= '0;
            present_reg    <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_flag_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
            out_closed_reg <= 1'b0;
            out_byte_reg   <= '0;
            out_pend_reg   <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (item_reg.segment_first)
                    begin
                        we_reg  <= item_reg.window_end;
                        ign_reg <= ign_cur;
                    end
                    fk_reg <= fk_n;
                    fi_reg <= fi_n;
                    if (close_now)
                    begin
                        closed_reg  <= 1'b1;
                        present_reg <= '0;
                        pending_reg <= '0;
                    end
                    else if (acc)
                    begin
                        present_reg[wslot] <= 1'b1;
                        if (!present_reg[wslot])
                        begin
                            pending_reg <= pending_reg + PW'(1);
                        end
                    end
                    n_reg     <= '0;
                    state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (ram_re)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else if (out_free)
                    begin
                        // nothing in order: one status word
                        out_flag_reg   <= 1'b0;
                        out_byte_reg   <= '0;
                        out_closed_reg <= closed_reg;
                        out_pend_reg   <= PEND_W'(pending_reg);
                        out_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_flag_reg   <= 1'b1;
                        out_byte_reg   <= ram_rdata;
                        out_closed_reg <= close_after;
                        out_pend_reg   <= close_after ? '0 : PEND_W'(pending_reg - PW'(1));
                        out_last_reg   <= last_n;
                        ne_reg         <= ne_inc;
                        ne_slot_reg    <= slot_inc;
                        n_reg          <= n_reg + DRAIN_W'(1);
                        if (close_after)
                        begin
                            closed_reg  <= 1'b1;
                            present_reg <= '0;
                            pending_reg <= '0;
                        end
                        else
                        begin
                            present_reg[ne_slot_reg] <= 1'b0;
                            pending_reg              <= pending_reg - PW'(1);
                        end
                        state_reg <= last_n ? ST_IDLE : ST_DRAIN;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_pend_reg, out_closed_reg, out_byte_reg};

    assign status.closed      = closed_reg;
    assign status.store_empty = (present_reg == '0) && (pending_reg == '0);
    assign status.pending_ok  = (pending_reg <= PW'(CAPACITY));

endmodule

@@ rtl/core/stream_byte_reassembler.sv @@
// flow: an accepted word waits in the two-word queue, the back end takes it in IDLE, applies it
// in EXEC, reads its first byte from the store in DRAIN and registers it for output in EMIT;
// each further byte repeats DRAIN and EMIT; nothing in order gives one status word
// throughput: one item at a time in the back end, bound by the registered store read
// a two-word queue lets the input side take words while the back end drains
// reset: asynchronous, clears window, present bits, end mark and closed state
module stream_byte_reassembler #(
    parameter int CAPACITY = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data,          // window_capacity
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,      // byte_index, in_byte, reader_consumed
    input  logic [2:0]   s_axis_tuser,      // segment_empty, segment_first, stream_end
    input  logic         s_axis_tlast,      // segment_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,      // out_byte, stream_closed, pending_bytes
    output logic         m_axis_tuser,      // out_valid
    output logic         m_axis_tlast       // last_result
);
    import sbr_pkg::*;

    logic        pop_valid, pop_ready;
    sbr_item_t   pop_item;
    sbr_status_t status;

    sbr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item)
    );

    sbr_back #(.CAPACITY(CAPACITY)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .status        (status)
    );

    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status.closed |=> status.closed)
        else $error("closed state dropped");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        status.closed |-> status.store_empty)
        else $error("store not empty after close");

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.pending_ok)
        else $error("pending count above capacity");

endmodule

@@ tb/sv/stream_byte_reassembler_tb.sv @@
module stream_byte_reassembler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbr_pkg::*;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_ROWS = 10;

    typedef struct packed {
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] in_byte;
        logic              seg_empty;
        logic              seg_first;
        logic              seg_last;
        logic              stream_end;
        logic [IDX_W-1:0]  consumed;
    } seg_word_t;

    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              closed;
        logic [PEND_W-1:0] pending;
        logic              last;
    } out_word_t;

    typedef struct packed {
        seg_word_t w;
        logic      typed;
        out_word_t res;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [6:0] cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [135:0] s_axis_tdata;      // byte_index, in_byte, reader_consumed
    logic [2:0] s_axis_tuser;        // segment_empty, segment_first, stream_end
    logic s_axis_tlast;              // segment_last
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;       // out_byte, stream_closed, pending_bytes
    logic m_axis_tuser;              // out_valid
    logic m_axis_tlast;              // last_result

    stream_byte_reassembler uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // reassembler state mirror
    logic [WCAP_W-1:0] win_cap;
    logic [IDX_W-1:0]  next_idx;
    logic [BYTE_W-1:0] slot_byte [SLOTS];
    logic              slot_full [SLOTS];
    int                held_bytes;
    logic [IDX_W-1:0]  win_end;
    logic              seg_dropped;
    logic [IDX_W-1:0]  end_idx;
    logic              end_known;
    logic              stream_shut;

    out_word_t   out_q[$];
    int          fails = 0;
    int          cycles = 0;
    bit          hold_req;
    logic [7:0]  pattern [256];
    row_t        dir_rows [N_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report(input string what, input out_word_t got, input out_word_t want);
        fails++;
        $display("mismatch %s: got v%0b b%02h c%0b p%0d l%0b want v%0b b%02h c%0b p%0d l%0b",
                 what, got.out_valid, got.out_byte, got.closed, got.pending, got.last,
                 want.out_valid, want.out_byte, want.closed, want.pending, want.last);
    endtask

    function automatic out_word_t make_out(logic v, logic [7:0] b);
        out_word_t r;
        r.out_valid = v;
        r.out_byte = b;
        r.closed = stream_shut;
        r.pending = held_bytes[PEND_W-1:0];
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void try_close();
        if (!stream_shut && end_known && next_idx >= end_idx)
        begin
            stream_shut = 1'b1;
            for (int i = 0; i < SLOTS; i++)
                slot_full[i] = 1'b0;
            held_bytes = 0;
        end
    endfunction

    // advance the mirror by one accepted word, return the words it drains
    function automatic void reassemble(input seg_word_t w, ref out_word_t res[$]);
        logic [IDX_W:0] sum;
        int slot;
        res.delete();
        if (w.seg_first)
        begin
            sum = {1'b0, w.consumed} + win_cap;
            win_end = sum[IDX_W] ? {IDX_W{1'b1}} : sum[IDX_W-1:0];
            seg_dropped = stream_shut || win_end <= next_idx || w.byte_index >= win_end;
        end
        if (!seg_dropped && !stream_shut)
        begin
            if (!w.seg_empty && w.byte_index >= next_idx && w.byte_index < win_end
                && w.byte_index - next_idx < SLOTS)
            begin
                slot = int'(w.byte_index % SLOTS);
                if (!slot_full[slot])
                begin
                    slot_full[slot] = 1'b1;
                    held_bytes++;
                end
                slot_byte[slot] = w.in_byte;
            end
            if (w.seg_last && w.stream_end)
            begin
                if (w.seg_empty)
                begin
                    if (w.byte_index < win_end)
                    begin
                        end_known = 1'b1;
                        end_idx = w.byte_index;
                    end
                end
                else if (w.byte_index < win_end && w.byte_index + 1 < win_end)
                begin
                    end_known = 1'b1;
                    end_idx = w.byte_index + 1;
                end
            end
        end
        try_close();
        while (!stream_shut && res.size() < DRAIN_MAX && slot_full[next_idx % SLOTS])
        begin
            slot = int'(next_idx % SLOTS);
            slot_full[slot] = 1'b0;
            held_bytes--;
            next_idx++;
            try_close();
            res.push_back(make_out(1'b1, slot_byte[slot]));
        end
        if (res.size() == 0)
            res.push_back(make_out(1'b0, 8'h00));
        res[res.size()-1].last = 1'b1;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        repeat (n) @(negedge clk);
    endtask

    task automatic send_word(input seg_word_t w, input bit typed, input out_word_t want);
        out_word_t res[$];
        idle_gap();
        s_axis_tdata = {w.consumed, w.in_byte, w.byte_index};
        s_axis_tuser = {w.stream_end, w.seg_first, w.seg_empty};
        s_axis_tlast = w.seg_last;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        reassemble(w, res);
        if (typed)
            out_q.push_back(want);
        else
            foreach (res[i])
                out_q.push_back(res[i]);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain_all();
        while (out_q.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_cap(input logic [6:0] v);
        drain_all();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        win_cap = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic seg_word_t mk(logic [63:0] idx, logic [7:0] b, logic e, logic f,
                                     logic l, logic se, logic [63:0] c);
        seg_word_t w;
        w.byte_index = idx;
        w.in_byte = b;
        w.seg_empty = e;
        w.seg_first = f;
        w.seg_last = l;
        w.stream_end = se;
        w.consumed = c;
        return w;
    endfunction

    function automatic out_word_t ow(logic v, logic [7:0] b, logic c, logic [6:0] p);
        out_word_t r;
        r.out_valid = v;
        r.out_byte = b;
        r.closed = c;
        r.pending = p;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [7:0] data_at(logic [63:0] idx);
        return pattern[idx[7:0]] ^ idx[15:8];
    endfunction

    // one substring starting near the in-order point, or noise
    task automatic random_segment(output int sent);
        logic [63:0] start, cons;
        int len, kind;
        kind = $urandom_range(0, 19);
        sent = 0;
        if (kind == 0)
        begin
            send_word(mk({$urandom, $urandom}, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                         1'b1, 1'b0, {$urandom, $urandom}), 1'b0, '0);
            sent = 1;
            return;
        end
        start = next_idx + $urandom_range(0, 40);
        start = (start >= 6) ? start - 6 : 0;
        cons = next_idx - ((next_idx >= 3) ? $urandom_range(0, 3) : 0);
        if (kind == 1)
        begin
            send_word(mk(start, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, cons), 1'b0, '0);
            sent = 1;
            return;
        end
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            // a broken substring leaves out its first item
            if (kind == 2 && i == 0)
                continue;
            send_word(mk(start + i, data_at(start + i), 1'b0, i == 0, i == len - 1,
                         1'b0, cons), 1'b0, '0);
            sent++;
        end
    endtask

    task automatic random_phase(input int items);
        int done, n;
        done = 0;
        while (done < items)
        begin
            random_segment(n);
            done += n;
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.out_valid = m_axis_tuser;
            got.out_byte = m_axis_tdata[7:0];
            got.closed = m_axis_tdata[8];
            got.pending = m_axis_tdata[15:9];
            got.last = m_axis_tlast;
            if (out_q.size() == 0)
                report("unexpected word", got, '0);
            else
            begin
                want = out_q[0];
                out_q.delete(0);
                if (got !== want)
                    report("result", got, want);
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (($urandom_range(0, 20) == 0) ? $urandom_range(10, 50)
                        : $urandom_range(0, 2)) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [63:0] ne;
        hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        win_cap = WCAP_RESET;
        next_idx = '0;
        held_bytes = 0;
        win_end = '0;
        seg_dropped = 1'b0;
        end_idx = '0;
        end_known = 1'b0;
        stream_shut = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_full[i] = 1'b0;
            slot_byte[i] = '0;
        end
        for (int i = 0; i < 256; i++)
            pattern[i] = 8'($urandom);

        // no first item yet, so the window is empty
        dir_rows[0] = '{mk(64'd0, 8'h11, 1'b0, 1'b0, 1'b1, 1'b0, 64'd0), 1'b1,
                        ow(1'b0, 8'h00, 1'b0, 7'd0)};
        dir_rows[1] = '{mk(64'd0, 8'hA5, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0), 1'b1,
                        ow(1'b1, 8'hA5, 1'b0, 7'd0)};
        dir_rows[2] = '{mk(64'd2, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0), 1'b1,
                        ow(1'b0, 8'h00, 1'b0, 7'd1)};
        dir_rows[3] = '{mk(64'd1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0), 1'b0, '0};
        // duplicate of an emitted byte
        dir_rows[4] = '{mk(64'd0, 8'hA5, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0), 1'b1,
                        ow(1'b0, 8'h00, 1'b0, 7'd0)};
        dir_rows[5] = '{mk('1, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0), 1'b1,
                        ow(1'b0, 8'h00, 1'b0, 7'd0)};
        // window end saturates
        dir_rows[6] = '{mk(64'd3, 8'h3C, 1'b0, 1'b1, 1'b1, 1'b0, '1), 1'b0, '0};
        dir_rows[7] = '{mk(64'd4, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 64'd4), 1'b0, '0};
        // end flag at the window edge is dropped
        dir_rows[8] = '{mk(64'd63, 8'h5A, 1'b0, 1'b1, 1'b1, 1'b1, 64'd0), 1'b0, '0};
        // byte right at the in-order point
        dir_rows[9] = '{mk(64'd4, 8'h77, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0), 1'b0, '0};

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

        write_cap(7'd64);
        hold_req = 1'b1;
        random_phase(60);
        write_cap(7'd1);
        random_phase(40);
        write_cap(7'($urandom_range(2, 63)));
        random_phase(50);
        write_cap(7'd64);
        random_phase(50);

        // end of stream: an end mark, overwritten by an earlier empty one
        drain_all();
        ne = next_idx;
        send_word(mk(ne + 5, data_at(ne + 5), 1'b0, 1'b1, 1'b1, 1'b1, ne), 1'b0, '0);
        send_word(mk(ne + 3, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, ne), 1'b0, '0);
        for (int i = 0; i < 3; i++)
            send_word(mk(ne + i, data_at(ne + i), 1'b0, i == 0, i == 2, 1'b0, ne), 1'b0, '0);
        for (int i = 0; i < 3; i++)
            send_word(mk(ne + 3 + i, 8'hC3, 1'b0, 1'b1, 1'b1, 1'b1, ne + 3), 1'b0, '0);

        drain_all();
        repeat (20) @(negedge clk);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
